// ----- src/lz10_lz11_stream_decompressor_top_assert.svh -----
// Assertion macros shared by the decompressor RTL.
// Depends on a clock named clk and an active-low reset named rst_n in the including module.
`ifndef LZ10_LZ11_STREAM_DECOMPRESSOR_TOP_ASSERT_SVH
`define LZ10_LZ11_STREAM_DECOMPRESSOR_TOP_ASSERT_SVH

// Same-cycle check: when ante holds, cons must hold on the same edge.
`define LZD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle check: when ante holds, cons must hold on the next edge (non-overlapping implication).
`define LZD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/lzd_pkg.sv -----
// Shared types, constants and codes for the LZ10/LZ11 decompressor.
// No dependencies; imported by every module of the block but lzd_ram.
package lzd_pkg;

  // History ring and counter sizes
  localparam int WINDOW_DEPTH = 4096;
  localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
  localparam int SIZE_BITS    = 24;
  localparam int LEN_BITS     = 17;
  localparam int CMP_BITS     = (SIZE_BITS > LEN_BITS) ? SIZE_BITS : LEN_BITS;
  localparam int FLAG_CNT_BITS = 4;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = SIZE_BITS;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_FORMAT_MODE = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_OUT_SIZE    = CFG_IDX_BITS'(1);

  // Item kinds and token formats
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;
  localparam logic FMT_LZ10  = 1'b0;

  // Token field constants
  localparam logic [FLAG_CNT_BITS-1:0] FLAGS_PER_BYTE = FLAG_CNT_BITS'(8);
  localparam logic [LEN_BITS-1:0] LZ10_LEN_BIAS  = LEN_BITS'(3);
  localparam logic [LEN_BITS-1:0] LZ11_LEN_BIAS  = LEN_BITS'(1);
  localparam logic [LEN_BITS-1:0] LZ11_EXT1_BIAS = LEN_BITS'('h11);
  localparam logic [LEN_BITS-1:0] LZ11_EXT2_BIAS = LEN_BITS'('h111);
  localparam logic [3:0] LZ11_HI_EXT1 = 4'h0;
  localparam logic [3:0] LZ11_HI_EXT2 = 4'h1;

  // Parser phase
  typedef enum logic [2:0] {
    PH_FLAG  = 3'd0,
    PH_ITEM  = 3'd1,
    PH_EXT1  = 3'd2,
    PH_EXT2A = 3'd3,
    PH_EXT2B = 3'd4,
    PH_LAST  = 3'd5,
    PH_COPY  = 3'd6,
    PH_DONE  = 3'd7
  } phase_t;

  // Input beat
  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       copy_pending;
    logic       done_res;
    logic       ignored;
  } out_item_t;

  // Parser decision for one beat, handed to the history stage
  typedef struct packed {
    logic              wr;
    logic              is_tick;
    logic [7:0]        lit;
    logic [WIN_AW-1:0] waddr;
    logic [WIN_AW-1:0] raddr;
    logic              copy_pending;
    logic              done_res;
    logic              ignored;
  } step_t;

endpackage

// ----- src/lzd_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module lzd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port; read returns old data on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/lzd_parser.sv -----
// Token parser: flag/literal/back-reference decode, copy bookkeeping and config.
// Depends on lzd_pkg and the assertion macro header.
`include "lz10_lz11_stream_decompressor_top_assert.svh"

module lzd_parser
  import lzd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic                     accept,
  input  in_item_t                 item,
  output step_t                    step
);

  phase_t                   phase_r, phase_nxt;
  logic                     format_mode_r;
  logic [WIN_AW-1:0]        write_pos_r, write_pos_nxt;
  logic [WIN_AW-1:0]        copy_pos_r, copy_pos_nxt;
  logic [LEN_BITS-1:0]      copy_left_r, copy_left_nxt;
  logic [SIZE_BITS-1:0]     bytes_rem_r, bytes_rem_nxt;
  logic [7:0]               flag_byte_r, flag_byte_nxt;
  logic [FLAG_CNT_BITS-1:0] flags_left_r, flags_left_nxt;
  logic [LEN_BITS-1:0]      length_acc_r, length_acc_nxt;
  logic [WIN_AW-1:0]        disp_acc_r, disp_acc_nxt;

  logic                     tok_done;
  logic                     wr;
  logic                     ign;
  logic [7:0]               b;
  logic [WIN_AW-1:0]        disp_full;
  logic [LEN_BITS-1:0]      len_clamp;
  phase_t                   resume_phase;

  assign b         = item.data_byte;
  assign disp_full = WIN_AW'({disp_acc_r[3:0], b});

  // Copy length clamped to the bytes still owed
  always_comb begin
    if (CMP_BITS'(length_acc_r) > CMP_BITS'(bytes_rem_r)) begin
      len_clamp = LEN_BITS'(bytes_rem_r);
    end else begin
      len_clamp = length_acc_r;
    end
  end

  // Datapath: counters, accumulators and flag shift for this beat
  always_comb begin
    write_pos_nxt  = write_pos_r;
    copy_pos_nxt   = copy_pos_r;
    copy_left_nxt  = copy_left_r;
    bytes_rem_nxt  = bytes_rem_r;
    flag_byte_nxt  = flag_byte_r;
    flags_left_nxt = flags_left_r;
    length_acc_nxt = length_acc_r;
    disp_acc_nxt   = disp_acc_r;
    tok_done       = 1'b0;
    wr             = 1'b0;
    ign            = 1'b0;
    if (item.kind == KIND_TICK) begin
      if (phase_r == PH_COPY && copy_left_r != '0) begin
        wr            = 1'b1;
        copy_pos_nxt  = copy_pos_r + WIN_AW'(1);
        write_pos_nxt = write_pos_r + WIN_AW'(1);
        copy_left_nxt = copy_left_r - LEN_BITS'(1);
      end else begin
        ign = 1'b1;
      end
    end else begin
      unique case (phase_r)
        PH_FLAG: begin
          flag_byte_nxt  = b;
          flags_left_nxt = FLAGS_PER_BYTE;
        end
        PH_ITEM: begin
          if (!flag_byte_r[7]) begin
            wr            = 1'b1;
            write_pos_nxt = write_pos_r + WIN_AW'(1);
            bytes_rem_nxt = bytes_rem_r - SIZE_BITS'(1);
            tok_done      = 1'b1;
          end else if (format_mode_r == FMT_LZ10) begin
            length_acc_nxt = LEN_BITS'(b[7:4]) + LZ10_LEN_BIAS;
            disp_acc_nxt   = WIN_AW'(b[3:0]);
          end else if (b[7:4] == LZ11_HI_EXT1) begin
            length_acc_nxt = LEN_BITS'({b, 4'h0});
          end else if (b[7:4] == LZ11_HI_EXT2) begin
            length_acc_nxt = LEN_BITS'({b[3:0], 12'h000});
          end else begin
            length_acc_nxt = LEN_BITS'(b[7:4]) + LZ11_LEN_BIAS;
            disp_acc_nxt   = WIN_AW'(b[3:0]);
          end
        end
        PH_EXT1: begin
          length_acc_nxt = (length_acc_r | LEN_BITS'(b[7:4])) + LZ11_EXT1_BIAS;
          disp_acc_nxt   = WIN_AW'(b[3:0]);
        end
        PH_EXT2A: begin
          length_acc_nxt = length_acc_r | LEN_BITS'({b, 4'h0});
        end
        PH_EXT2B: begin
          length_acc_nxt = (length_acc_r | LEN_BITS'(b[7:4])) + LZ11_EXT2_BIAS;
          disp_acc_nxt   = WIN_AW'(b[3:0]);
        end
        PH_LAST: begin
          disp_acc_nxt  = disp_full;
          bytes_rem_nxt = bytes_rem_r - SIZE_BITS'(len_clamp);
          copy_pos_nxt  = write_pos_r - disp_full - WIN_AW'(1);
          copy_left_nxt = len_clamp;
          tok_done      = 1'b1;
        end
        default: begin
          // copy running or stream finished: byte is dropped
          ign = 1'b1;
        end
      endcase
    end
    // consume one flag bit per finished token
    if (tok_done) begin
      flag_byte_nxt = {flag_byte_r[6:0], 1'b0};
      if (flags_left_r != '0) begin
        flags_left_nxt = flags_left_r - FLAG_CNT_BITS'(1);
      end
    end
  end

  // Phase to go to once a token or copy has finished
  always_comb begin
    if (bytes_rem_nxt == '0) begin
      resume_phase = PH_DONE;
    end else if (flags_left_nxt == '0) begin
      resume_phase = PH_FLAG;
    end else begin
      resume_phase = PH_ITEM;
    end
  end

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (item.kind == KIND_TICK) begin
      if (wr && copy_left_nxt == '0) begin
        phase_nxt = resume_phase;
      end
    end else if (tok_done) begin
      phase_nxt = (copy_left_nxt != '0) ? PH_COPY : resume_phase;
    end else begin
      unique case (phase_r)
        PH_FLAG:  phase_nxt = PH_ITEM;
        PH_ITEM: begin
          if (format_mode_r == FMT_LZ10) begin
            phase_nxt = PH_LAST;
          end else if (b[7:4] == LZ11_HI_EXT1) begin
            phase_nxt = PH_EXT1;
          end else if (b[7:4] == LZ11_HI_EXT2) begin
            phase_nxt = PH_EXT2A;
          end else begin
            phase_nxt = PH_LAST;
          end
        end
        PH_EXT1:  phase_nxt = PH_LAST;
        PH_EXT2A: phase_nxt = PH_EXT2B;
        PH_EXT2B: phase_nxt = PH_LAST;
        default:  phase_nxt = phase_r;
      endcase
    end
  end

  // Step handed to the history stage
  always_comb begin
    step.wr           = wr;
    step.is_tick      = (item.kind == KIND_TICK);
    step.lit          = b;
    step.waddr        = write_pos_r;
    step.raddr        = copy_pos_r;
    step.copy_pending = (copy_left_nxt != '0);
    step.done_res     = (bytes_rem_nxt == '0) && (copy_left_nxt == '0);
    step.ignored      = ign;
  end

  // State registers; a size write restarts the stream
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_DONE;
      format_mode_r <= FMT_LZ10;
      write_pos_r   <= '0;
      copy_pos_r    <= '0;
      copy_left_r   <= '0;
      bytes_rem_r   <= '0;
      flag_byte_r   <= '0;
      flags_left_r  <= '0;
      length_acc_r  <= '0;
      disp_acc_r    <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_FORMAT_MODE) begin
        format_mode_r <= cfg_wdata[0];
      end else if (cfg_index == REG_OUT_SIZE) begin
        phase_r      <= (SIZE_BITS'(cfg_wdata) == '0) ? PH_DONE : PH_FLAG;
        write_pos_r  <= '0;
        copy_pos_r   <= '0;
        copy_left_r  <= '0;
        bytes_rem_r  <= SIZE_BITS'(cfg_wdata);
        flag_byte_r  <= '0;
        flags_left_r <= '0;
        length_acc_r <= '0;
        disp_acc_r   <= '0;
      end
    end else if (accept) begin
      phase_r      <= phase_nxt;
      write_pos_r  <= write_pos_nxt;
      copy_pos_r   <= copy_pos_nxt;
      copy_left_r  <= copy_left_nxt;
      bytes_rem_r  <= bytes_rem_nxt;
      flag_byte_r  <= flag_byte_nxt;
      flags_left_r <= flags_left_nxt;
      length_acc_r <= length_acc_nxt;
      disp_acc_r   <= disp_acc_nxt;
    end
  end

  `LZD_ASSERT_SAME(a_copy_phase_match, 1'b1, (copy_left_r != '0) == (phase_r == PH_COPY), "copy count and copy phase disagree")
  `LZD_ASSERT_SAME(a_done_drained, phase_r == PH_DONE, bytes_rem_r == '0 && copy_left_r == '0, "done phase with bytes still owed")
  `LZD_ASSERT_SAME(a_flags_bound, 1'b1, flags_left_r <= FLAGS_PER_BYTE, "flag counter out of range")
  `LZD_ASSERT_NEXT(a_copy_advance, accept && !cfg_we && wr && item.kind == KIND_TICK, copy_pos_r == $past(copy_pos_r) + WIN_AW'(1), "copy pointer did not advance")

endmodule

// ----- src/lzd_hist.sv -----
// History stage: 4096-byte ring RAM, copy read with forwarding, byte write-back.
// Depends on lzd_pkg and lzd_ram.
module lzd_hist
  import lzd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  step_t     step,
  input  logic      drain,
  output logic      s1_valid,
  output out_item_t s1_item
);

  logic       s1_v_r, s1_v_nxt;
  step_t      s1_step_r;
  logic       s1_fwd_r;
  logic [7:0] s1_fwd_byte_r;
  logic [7:0] ram_rdata;
  logic [7:0] s1_byte;
  logic       ram_we;
  logic       ram_re;
  logic       fwd_hit;

  // Byte of the beat in this stage: literal, forwarded write, or ring read
  always_comb begin
    if (!s1_step_r.is_tick) begin
      s1_byte = s1_step_r.lit;
    end else if (s1_fwd_r) begin
      s1_byte = s1_fwd_byte_r;
    end else begin
      s1_byte = ram_rdata;
    end
  end

  // Write back once, when the beat leaves; read on accepted copy ticks
  assign ram_we = s1_v_r && drain && s1_step_r.wr;
  assign ram_re = accept && step.wr && step.is_tick;

  // A read that hits the write going out on the same edge takes the byte directly
  assign fwd_hit = s1_v_r && s1_step_r.wr && (s1_step_r.waddr == step.raddr);

  lzd_ram #(
    .WIDTH(8),
    .DEPTH(WINDOW_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(s1_step_r.waddr),
    .wdata(s1_byte),
    .re   (ram_re),
    .raddr(step.raddr),
    .rdata(ram_rdata)
  );

  // Stage occupancy
  always_comb begin
    if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (drain) begin
      s1_v_nxt = 1'b0;
    end else begin
      s1_v_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_step_r     <= step;
      s1_fwd_r      <= fwd_hit;
      s1_fwd_byte_r <= s1_byte;
    end
  end

  assign s1_valid = s1_v_r;

  always_comb begin
    s1_item.out_valid    = s1_step_r.wr;
    s1_item.out_byte     = s1_step_r.wr ? s1_byte : 8'h00;
    s1_item.copy_pending = s1_step_r.copy_pending;
    s1_item.done_res     = s1_step_r.done_res;
    s1_item.ignored      = s1_step_r.ignored;
  end

endmodule

// ----- src/lz10_lz11_stream_decompressor_top.sv -----
// LZ10/LZ11 decompressor top level: parser, history stage and result register.
// Depends on lzd_pkg, lzd_parser, lzd_hist and the assertion macro header.
//
// The block takes one beat per clock, byte or tick, while in_stall is low, and
// returns one result beat for each, passing through the history stage, then
// the result register. The rate is set by the history ring: one 4096 x 8 RAM with
// one read and one write per cycle; a copy tick whose source byte is still
// being written (displacement zero) is served by forwarding. The ring is not
// cleared after reset, so no startup pass is needed. in_stall rises only when
// the history stage and the result register are both full and the output
// side stalls. Write configuration only while no beat is in flight; writing
// out_size restarts the stream and keeps the ring contents.
`include "lz10_lz11_stream_decompressor_top_assert.svh"

module lz10_lz11_stream_decompressor_top
  import lzd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_item_t                out_data
);

  step_t     step;
  logic      accept;
  logic      drain;
  logic      s1_valid;
  out_item_t s1_item;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  // Handshake: stage moves on when the result register is free or emptying
  assign drain    = !out_valid_r || !out_stall;
  assign in_stall = s1_valid && !drain;
  assign accept   = in_valid && !in_stall;

  lzd_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .accept   (accept),
    .item     (in_data),
    .step     (step)
  );

  lzd_hist u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .step    (step),
    .drain   (drain),
    .s1_valid(s1_valid),
    .s1_item (s1_item)
  );

  // Result register
  always_comb begin
    if (s1_valid && drain) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && drain) begin
      out_data_r <= s1_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `LZD_ASSERT_SAME(a_ignored_empty, out_valid_r && out_data_r.ignored, !out_data_r.out_valid && out_data_r.out_byte == 8'h00, "dropped beat carries a byte")
  `LZD_ASSERT_SAME(a_stall_only_full, in_stall, out_valid_r && s1_valid, "input stalled with room in the pipeline")

endmodule

// ----- tb/lzd_checker.sv -----
// Scoreboard for the LZ10/LZ11 decompressor: follows the config port and both channels,
// predicts every result beat from its own copy of the decoder state and compares in order.
// Depends on lzd_pkg for the beat types, phases and token constants.
module lzd_checker
  import lzd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  in_item_t                 in_data,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  out_item_t                out_data,
  output int                       owed_results,
  output int                       mismatches
);

  // Decoder copy: registers and stream state
  logic                     fmt_sel;
  logic [SIZE_BITS-1:0]     size_cfg;
  logic [SIZE_BITS-1:0]     bytes_owed;
  logic [7:0]               ring [WINDOW_DEPTH];
  logic [WIN_AW-1:0]        wr_ptr;
  logic [WIN_AW-1:0]        rd_ptr;
  logic [7:0]               flag_sr;
  logic [FLAG_CNT_BITS-1:0] flag_cnt;
  phase_t                   phase;
  logic [LEN_BITS-1:0]      run_acc;
  logic [LEN_BITS-1:0]      run_left;
  logic [WIN_AW-1:0]        dist_acc;

  out_item_t expected_beats [$];
  int        errs = 0;

  // Out_size write or reset: parser, copy and write pointer cleared, ring kept
  function automatic void restart_stream();
    wr_ptr     = '0;
    rd_ptr     = '0;
    bytes_owed = size_cfg;
    flag_sr    = '0;
    flag_cnt   = '0;
    run_acc    = '0;
    dist_acc   = '0;
    run_left   = '0;
    if (bytes_owed == 0) phase = PH_DONE;
    else phase = PH_FLAG;
  endfunction

  function automatic void push_history(input logic [7:0] v);
    ring[wr_ptr] = v;
    wr_ptr = wr_ptr + 1'b1;
  endfunction

  // Where the parser goes once no copy is running
  function automatic phase_t phase_after_run();
    if (bytes_owed == 0) return PH_DONE;
    if (flag_cnt == 0) return PH_FLAG;
    return PH_ITEM;
  endfunction

  // End of a token: shift out its flag bit
  function automatic void close_token();
    flag_sr = flag_sr << 1;
    if (flag_cnt != 0) flag_cnt = flag_cnt - 1'b1;
    if (run_left != 0) phase = PH_COPY;
    else phase = phase_after_run();
  endfunction

  // One accepted beat in, one predicted result out
  function automatic out_item_t decode_beat(input in_item_t beat);
    out_item_t           r;
    logic [7:0]          b;
    logic [7:0]          v;
    logic [LEN_BITS-1:0] run;
    r = '0;
    b = beat.data_byte;
    if (beat.kind == KIND_TICK) begin
      if (phase == PH_COPY && run_left != 0) begin
        v = ring[rd_ptr];
        rd_ptr = rd_ptr + 1'b1;
        push_history(v);
        run_left = run_left - 1'b1;
        r.out_valid = 1'b1;
        r.out_byte  = v;
        if (run_left == 0) phase = phase_after_run();
      end else begin
        r.ignored = 1'b1;
      end
    end else begin
      case (phase)
        PH_FLAG: begin
          flag_sr  = b;
          flag_cnt = FLAGS_PER_BYTE;
          phase    = PH_ITEM;
        end
        PH_ITEM: begin
          if (!flag_sr[7]) begin
            // literal goes straight out
            push_history(b);
            r.out_valid = 1'b1;
            r.out_byte  = b;
            bytes_owed  = bytes_owed - 1'b1;
            close_token();
          end else if (fmt_sel == FMT_LZ10) begin
            run_acc  = LEN_BITS'(b[7:4]) + LZ10_LEN_BIAS;
            dist_acc = WIN_AW'(b[3:0]);
            phase    = PH_LAST;
          end else if (b[7:4] == LZ11_HI_EXT1) begin
            run_acc = LEN_BITS'({b, 4'h0});
            phase   = PH_EXT1;
          end else if (b[7:4] == LZ11_HI_EXT2) begin
            run_acc = LEN_BITS'({b[3:0], 12'h000});
            phase   = PH_EXT2A;
          end else begin
            run_acc  = LEN_BITS'(b[7:4]) + LZ11_LEN_BIAS;
            dist_acc = WIN_AW'(b[3:0]);
            phase    = PH_LAST;
          end
        end
        PH_EXT1: begin
          run_acc  = (run_acc | LEN_BITS'(b[7:4])) + LZ11_EXT1_BIAS;
          dist_acc = WIN_AW'(b[3:0]);
          phase    = PH_LAST;
        end
        PH_EXT2A: begin
          run_acc = run_acc | LEN_BITS'({b, 4'h0});
          phase   = PH_EXT2B;
        end
        PH_EXT2B: begin
          run_acc  = (run_acc | LEN_BITS'(b[7:4])) + LZ11_EXT2_BIAS;
          dist_acc = WIN_AW'(b[3:0]);
          phase    = PH_LAST;
        end
        PH_LAST: begin
          // last token byte: clamp the run to what is still owed, aim the copy
          dist_acc = {dist_acc[3:0], b};
          run = run_acc;
          if (SIZE_BITS'(run) > bytes_owed) run = LEN_BITS'(bytes_owed);
          bytes_owed = bytes_owed - SIZE_BITS'(run);
          rd_ptr     = wr_ptr - dist_acc - 1'b1;
          run_left   = run;
          close_token();
        end
        default: r.ignored = 1'b1;
      endcase
    end
    r.copy_pending = (run_left != 0);
    r.done_res     = (bytes_owed == 0) && (run_left == 0);
    return r;
  endfunction

  // Per edge: config first, then the result beat, then the new input beat
  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      fmt_sel  = FMT_LZ10;
      size_cfg = '0;
      restart_stream();
      expected_beats.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_FORMAT_MODE) begin
          fmt_sel = cfg_wdata[0];
        end else if (cfg_index == REG_OUT_SIZE) begin
          size_cfg = cfg_wdata[SIZE_BITS-1:0];
          restart_stream();
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          errs++;
          $display("%0t: result beat with nothing expected: valid=%0d byte=%02h pend=%0d done=%0d ign=%0d",
                   $time, out_data.out_valid, out_data.out_byte, out_data.copy_pending,
                   out_data.done_res, out_data.ignored);
        end else begin
          want = expected_beats.pop_front();
          if (out_data.out_valid !== want.out_valid || out_data.out_byte !== want.out_byte ||
              out_data.copy_pending !== want.copy_pending ||
              out_data.done_res !== want.done_res || out_data.ignored !== want.ignored) begin
            errs++;
            $display("%0t: mismatch, expected valid=%0d byte=%02h pend=%0d done=%0d ign=%0d",
                     $time, want.out_valid, want.out_byte, want.copy_pending,
                     want.done_res, want.ignored);
            $display("%0t:           actual   valid=%0d byte=%02h pend=%0d done=%0d ign=%0d",
                     $time, out_data.out_valid, out_data.out_byte, out_data.copy_pending,
                     out_data.done_res, out_data.ignored);
          end
        end
      end
      if (in_valid && !in_stall) expected_beats.push_back(decode_beat(in_data));
    end
    owed_results <= expected_beats.size();
    mismatches   <= errs;
  end

endmodule

// ----- tb/tb.sv -----
// Top of the decompressor testbench: clock, reset, well-formed LZ10/LZ11 streams with
// stray and broken beats, random idling on both channels, and the final verdict.
// Depends on lzd_pkg, lz10_lz11_stream_decompressor_top and lzd_checker.
module tb;
  import lzd_pkg::*;

  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          RANDOM_ITEMS = 950;
  localparam int          CALM_FROM    = 400;
  localparam int          CALM_TO      = 600;
  localparam int unsigned LONG_OWED    = 600;
  localparam logic        FMT_LZ11     = ~FMT_LZ10;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = CFG_IDX_BITS'(3);

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;
  logic                     in_valid;
  logic                     in_stall;
  in_item_t                 in_data;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  out_item_t                out_data;
  int                       owed_results;
  int                       mismatches;

  // Stimulus bookkeeping
  logic                     calm = 1'b0;
  logic                     mode_now;
  int unsigned              left_owed;
  int unsigned              left_copy;
  int unsigned              made;
  int unsigned              flags_left;
  logic [7:0]               flag_bits;
  int unsigned              real_beats = 0;
  int unsigned              stray_beats = 0;
  int unsigned              streams = 0;
  int unsigned              cycle_cnt = 0;

  always #2 clk = ~clk;

  lz10_lz11_stream_decompressor_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  lzd_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .owed_results (owed_results),
    .mismatches   (mismatches)
  );

  // Receiver back-pressure, switched off in the calm stretch
  always @(posedge clk) out_stall <= !calm && ($urandom_range(99) < 35);

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_cnt, owed_results);
      $display("tb NOT OK");
      $finish;
    end
  end

  // One beat: random idle cycles first, then hold until accepted
  task automatic send_beat(input logic k, input logic [7:0] b, input bit stray);
    in_item_t beat;
    beat.kind      = k;
    beat.data_byte = b;
    calm = (real_beats >= CALM_FROM) && (real_beats < CALM_TO);
    while (!calm && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (stray) stray_beats++;
    else real_beats++;
  endtask

  // Stop sending and wait until every predicted result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (owed_results != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // A well-formed stream with random content; cut_at >= 0 abandons it at that token,
  // part way through the token when it is a back-reference
  task automatic play_stream(input logic [SIZE_BITS-1:0] size, input int cut_at);
    logic [7:0]  code [4];
    logic [3:0]  hi4;
    logic [15:0] ext;
    int          n;
    int          keep;
    int          tok;
    int unsigned run;
    int unsigned reach;
    int unsigned back;
    write_reg(REG_OUT_SIZE, CFG_DATA_BITS'(size));
    streams++;
    left_owed  = size;
    left_copy  = 0;
    made       = 0;
    flags_left = 0;
    flag_bits  = '0;
    tok        = 0;
    while ((left_owed != 0 || left_copy != 0) && tok != cut_at) begin
      if (left_copy != 0) begin
        // copy running: ticks, now and then a byte that must be dropped
        if ($urandom_range(99) < 4) send_beat(KIND_BYTE, 8'($urandom), 1'b1);
        send_beat(KIND_TICK, 8'($urandom), 1'b0);
        left_copy--;
        made++;
      end else begin
        if ($urandom_range(99) < 3) send_beat(KIND_TICK, 8'($urandom), 1'b1);
        if (flags_left == 0) begin
          flag_bits = 8'($urandom);
          if (made == 0) flag_bits[7] = 1'b0;
          send_beat(KIND_BYTE, flag_bits, 1'b0);
          flags_left = 8;
        end else if (!flag_bits[7]) begin
          send_beat(KIND_BYTE, 8'($urandom), 1'b0);
          made++;
          left_owed--;
          tok++;
          flag_bits  = flag_bits << 1;
          flags_left--;
        end else begin
          // back-reference, never reaching before this stream's first byte
          reach = (made < WINDOW_DEPTH) ? made : WINDOW_DEPTH;
          back  = $urandom_range(reach - 1, 0);
          if ($urandom_range(1) == 1) back = back % 4;
          if (mode_now == FMT_LZ10) begin
            hi4     = 4'($urandom);
            run     = hi4 + LZ10_LEN_BIAS;
            code[0] = {hi4, back[11:8]};
            code[1] = back[7:0];
            n       = 2;
          end else begin
            case ($urandom_range(2))
              0: begin
                hi4     = 4'($urandom_range(15, 2));
                run     = hi4 + LZ11_LEN_BIAS;
                code[0] = {hi4, back[11:8]};
                code[1] = back[7:0];
                n       = 2;
              end
              1: begin
                // 8-bit length field split over the first two token bytes
                ext     = ($urandom_range(1) == 1 || left_owed > LONG_OWED)
                          ? 16'($urandom_range(15, 0)) : 16'($urandom_range(255, 0));
                run     = ext[7:0] + LZ11_EXT1_BIAS;
                code[0] = {LZ11_HI_EXT1, ext[7:4]};
                code[1] = {ext[3:0], back[11:8]};
                code[2] = back[7:0];
                n       = 3;
              end
              default: begin
                // long runs only where the size clamps them
                if (left_owed > LONG_OWED) begin
                  ext = 16'($urandom_range(31, 0));
                end else begin
                  case ($urandom_range(9))
                    0:       ext = 16'hFFFF;
                    1, 2, 3: ext = 16'($urandom);
                    default: ext = 16'($urandom_range(31, 0));
                  endcase
                end
                run     = ext + LZ11_EXT2_BIAS;
                code[0] = {LZ11_HI_EXT2, ext[15:12]};
                code[1] = ext[11:4];
                code[2] = {ext[3:0], back[11:8]};
                code[3] = back[7:0];
                n       = 4;
              end
            endcase
          end
          tok++;
          keep = (tok == cut_at) ? $urandom_range(n - 1, 1) : n;
          for (int i = 0; i < keep; i++) begin
            if (i == 1 && keep == n && $urandom_range(99) < 6) begin
              // format flip inside a token; the token ends in the format it began in
              mode_now = ~mode_now;
              write_reg(REG_FORMAT_MODE, CFG_DATA_BITS'(mode_now));
            end
            if (i != 0 && $urandom_range(99) < 3) send_beat(KIND_TICK, 8'($urandom), 1'b1);
            send_beat(KIND_BYTE, code[i], 1'b0);
          end
          if (keep == n) begin
            if (run > left_owed) run = left_owed;
            left_owed -= run;
            left_copy  = run;
          end
          flag_bits  = flag_bits << 1;
          flags_left--;
        end
      end
    end
    // after done every beat is dropped
    if (left_owed == 0 && left_copy == 0) begin
      n = (size == 0) ? 2 : $urandom_range(1);
      repeat (n) send_beat(1'($urandom), 8'($urandom), 1'b1);
    end
  endtask

  initial begin : stimulus
    logic [SIZE_BITS-1:0] size;
    int                   cut;
    int unsigned          stop_at;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    mode_now  = FMT_LZ10;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Out of reset the size is zero: already done, everything dropped
    send_beat(KIND_TICK, 8'h00, 1'b1);
    send_beat(KIND_BYTE, 8'hFF, 1'b1);

    // LZ10: literal, then an overlapping copy (displacement 0) clamped to 2 bytes
    write_reg(REG_FORMAT_MODE, CFG_DATA_BITS'(FMT_LZ10));
    write_reg(REG_OUT_SIZE, CFG_DATA_BITS'(3));
    send_beat(KIND_BYTE, 8'h40, 1'b0);
    send_beat(KIND_BYTE, 8'hFF, 1'b0);
    send_beat(KIND_BYTE, 8'hF0, 1'b0);
    send_beat(KIND_BYTE, 8'h00, 1'b0);
    send_beat(KIND_BYTE, 8'h5A, 1'b1);
    repeat (2) send_beat(KIND_TICK, 8'h00, 1'b0);

    // Unknown register indexes must not touch anything
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, '1);

    // LZ11: literal, short form (len 3), one-extra-byte form clamped to 2
    mode_now = FMT_LZ11;
    write_reg(REG_FORMAT_MODE, CFG_DATA_BITS'(FMT_LZ11));
    write_reg(REG_OUT_SIZE, CFG_DATA_BITS'(6));
    send_beat(KIND_BYTE, 8'h70, 1'b0);
    send_beat(KIND_BYTE, 8'h00, 1'b0);
    send_beat(KIND_BYTE, 8'h20, 1'b0);
    send_beat(KIND_BYTE, 8'h00, 1'b0);
    repeat (3) send_beat(KIND_TICK, 8'hFF, 1'b0);
    send_beat(KIND_BYTE, 8'h00, 1'b0);
    send_beat(KIND_BYTE, 8'h10, 1'b0);
    send_beat(KIND_BYTE, 8'h01, 1'b0);
    repeat (2) send_beat(KIND_TICK, 8'h00, 1'b0);

    // LZ11 two-extra-byte form at its longest length, clamped to one byte
    write_reg(REG_OUT_SIZE, CFG_DATA_BITS'(2));
    send_beat(KIND_BYTE, 8'h40, 1'b0);
    send_beat(KIND_BYTE, 8'h81, 1'b0);
    send_beat(KIND_BYTE, 8'h1F, 1'b0);
    send_beat(KIND_BYTE, 8'hFF, 1'b0);
    send_beat(KIND_BYTE, 8'hF0, 1'b0);
    send_beat(KIND_BYTE, 8'h00, 1'b0);
    send_beat(KIND_TICK, 8'h00, 1'b0);

    // Random streams: largest size (abandoned), zero size, one byte, then a mix
    stop_at = real_beats + RANDOM_ITEMS;
    play_stream('1, 8);
    play_stream('0, -1);
    play_stream(SIZE_BITS'(1), -1);
    while (real_beats < stop_at) begin
      if ($urandom_range(99) < 30) begin
        mode_now = 1'($urandom);
        write_reg(REG_FORMAT_MODE, CFG_DATA_BITS'(mode_now));
      end
      case ($urandom_range(19))
        0:       size = SIZE_BITS'(1);
        1, 2:    size = SIZE_BITS'($urandom_range(600, 100));
        default: size = SIZE_BITS'($urandom_range(40, 2));
      endcase
      cut = ($urandom_range(99) < 15) ? $urandom_range(12, 0) : -1;
      play_stream(size, cut);
    end

    // Let everything drain, then wait for anything stray before the verdict
    drain();
    repeat (8) @(posedge clk);
    $display("covered %0d streams: %0d stream beats and %0d beats meant to be dropped",
             streams, real_beats, stray_beats);
    $display("both token formats, clamped and overlapping copies, restarts and format flips");
    if (mismatches == 0 && owed_results == 0) begin
      $display("tb OK");
    end else begin
      $display("%0d mismatches, %0d results owed", mismatches, owed_results);
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
